// ===== rtl/core/ugf_pkg.sv =====
`default_nettype none
package ugf_pkg;

	localparam int QDepth = 2;
	localparam int QPtrW  = 1;
	localparam int QCntW  = 2;

	localparam logic [7:0] NUL = 8'h00;

	// folded byte string, bytes[0] goes out first
	typedef struct packed {
		logic [3:0][7:0] bytes;
		logic [2:0]      cnt;
	} fold_t;

	typedef struct packed {
		logic  valid;
		fold_t entry;
	} q_port_t;

	function automatic fold_t str(input logic [7:0] c0, input logic [7:0] c1,
			input logic [7:0] c2, input logic [7:0] c3, input logic [2:0] n);
		fold_t f;
		f.bytes = {c3, c2, c1, c0};
		f.cnt   = n;
		return f;
	endfunction

	function automatic fold_t none_str();
		return str(NUL, NUL, NUL, NUL, 3'd0);
	endfunction

	function automatic fold_t utf8(input logic [20:0] cp);
		fold_t f;
		if (cp < 21'h000080) begin
			f = str({1'b0, cp[6:0]}, NUL, NUL, NUL, 3'd1);
		end else if (cp < 21'h000800) begin
			f = str({3'b110, cp[10:6]}, {2'b10, cp[5:0]}, NUL, NUL, 3'd2);
		end else if (cp < 21'h010000) begin
			f = str({4'b1110, cp[15:12]}, {2'b10, cp[11:6]}, {2'b10, cp[5:0]},
				NUL, 3'd3);
		end else begin
			f = str({5'b11110, cp[20:18]}, {2'b10, cp[17:12]}, {2'b10, cp[11:6]},
				{2'b10, cp[5:0]}, 3'd4);
		end
		return f;
	endfunction

	function automatic fold_t one(input logic [7:0] c0);
		return str(c0, NUL, NUL, NUL, 3'd1);
	endfunction

	function automatic fold_t two(input logic [7:0] c0, input logic [7:0] c1);
		return str(c0, c1, NUL, NUL, 3'd2);
	endfunction

	function automatic fold_t greek_letter(input logic [9:0] cp);
		fold_t f;
		case (cp) inside
			10'h391, 10'h386:                   f = one("A");
			10'h392:                            f = one("B");
			10'h393:                            f = one("G");
			10'h394:                            f = one("D");
			10'h395, 10'h397, 10'h388, 10'h389: f = one("E");
			10'h396:                            f = one("Z");
			10'h398:                            f = two("T", "h");
			10'h399, 10'h38A:                   f = one("I");
			10'h39A:                            f = one("K");
			10'h39B:                            f = one("L");
			10'h39C:                            f = one("M");
			10'h39D:                            f = one("N");
			10'h39E:                            f = one("X");
			10'h39F, 10'h3A9, 10'h38C, 10'h38F: f = one("O");
			10'h3A0:                            f = one("P");
			10'h3A1:                            f = one("R");
			10'h3A3:                            f = one("S");
			10'h3A4:                            f = one("T");
			10'h3A5, 10'h38E:                   f = one("Y");
			10'h3A6:                            f = two("P", "h");
			10'h3A7:                            f = two("C", "h");
			10'h3A8:                            f = two("P", "s");
			10'h3B1, 10'h3AC:                   f = one("a");
			10'h3B2:                            f = one("b");
			10'h3B3:                            f = one("g");
			10'h3B4:                            f = one("d");
			10'h3B5, 10'h3B7, 10'h3AD, 10'h3AE: f = one("e");
			10'h3B6:                            f = one("z");
			10'h3B8:                            f = two("t", "h");
			10'h3B9, 10'h3AF, 10'h3CA, 10'h390: f = one("i");
			10'h3BA:                            f = one("k");
			10'h3BB:                            f = one("l");
			10'h3BC:                            f = one("m");
			10'h3BD:                            f = one("n");
			10'h3BE:                            f = one("x");
			10'h3BF, 10'h3C9, 10'h3CC, 10'h3CE: f = one("o");
			10'h3C0:                            f = one("p");
			10'h3C1:                            f = one("r");
			10'h3C2, 10'h3C3:                   f = one("s");
			10'h3C4:                            f = one("t");
			10'h3C5, 10'h3CD, 10'h3CB, 10'h3B0: f = one("y");
			10'h3C6:                            f = two("p", "h");
			10'h3C7:                            f = two("c", "h");
			10'h3C8:                            f = two("p", "s");
			default:                            f = none_str();
		endcase
		return f;
	endfunction

	function automatic fold_t vowel_row(input logic [3:0] sel);
		fold_t f;
		case (sel) inside
			4'h0:       f = one("a");
			4'h1, 4'h2: f = one("e");
			4'h3:       f = one("i");
			4'h4, 4'h6: f = one("o");
			default:    f = one("y");
		endcase
		return f;
	endfunction

	// offset within greek extended block
	function automatic fold_t greek_ext(input logic [7:0] off);
		fold_t f;
		if (off <= 8'h6F)                     f = vowel_row(off[7:4]);
		else if (off <= 8'h7D)                f = vowel_row({1'b0, off[3:1]});
		else if (off <= 8'h7F)                f = none_str();
		else if (off <= 8'h8F)                f = one("a");
		else if (off <= 8'h9F)                f = one("e");
		else if (off <= 8'hAF)                f = one("o");
		else if (off <= 8'hBC)                f = one("a");
		else if (off <= 8'hBF)                f = none_str();
		else if (off <= 8'hCC)                f = one("e");
		else if (off <= 8'hCF)                f = none_str();
		else if (off <= 8'hDF)                f = one("i");
		else if (off == 8'hE5 || off == 8'hEC) f = one("r");
		else if (off <= 8'hEF)                f = one("y");
		else                                  f = one("o");
		return f;
	endfunction

	function automatic fold_t symbol_map(input logic [20:0] cp, output logic hit);
		fold_t f;
		hit = 1'b1;
		case (cp) inside
			21'h2122:                   f = str("(", "T", "M", ")", 3'd4);
			21'h2120:                   f = str("(", "S", "M", ")", 3'd4);
			21'h2117:                   f = str("(", "P", ")", NUL, 3'd3);
			21'h2190:                   f = two("<", "-");
			21'h2192:                   f = two("-", ">");
			21'h2194:                   f = str("<", "-", ">", NUL, 3'd3);
			21'h21D2:                   f = two("=", ">");
			21'h21D0, 21'h2264:         f = two("<", "=");
			21'h2191:                   f = one("^");
			21'h2193, 21'h2713, 21'h2714: f = one("v");
			21'h2248:                   f = one("~");
			21'h2260:                   f = two("!", "=");
			21'h2265:                   f = two(">", "=");
			21'h2219, 21'h2605, 21'h2606: f = one("*");
			21'h2665, 21'h2764:         f = two("<", "3");
			default: begin
				f   = none_str();
				hit = 1'b0;
			end
		endcase
		return f;
	endfunction

	function automatic fold_t fold_cp(input logic [20:0] cp);
		fold_t f;
		fold_t sym;
		logic  sym_hit;
		logic  pass;
		logic  drop;
		pass = (cp < 21'h000370) || (cp >= 21'h000400 && cp <= 21'h0004FF) ||
			(cp >= 21'h002012 && cp <= 21'h002064) ||
			(cp >= 21'h0020A0 && cp <= 21'h0020C0);
		drop = (cp >= 21'h01F000 && cp <= 21'h01FAFF) ||
			(cp >= 21'h002300 && cp <= 21'h0027BF) ||
			(cp >= 21'h002B00 && cp <= 21'h002BFF) ||
			(cp >= 21'h00FE00 && cp <= 21'h00FE0F) ||
			cp == 21'h00200D || cp == 21'h002060;
		sym = symbol_map(cp, sym_hit);
		if (pass)                                         f = utf8(cp);
		else if (cp <= 21'h0003FF)                        f = greek_letter(cp[9:0]);
		else if (cp >= 21'h001F00 && cp <= 21'h001FFF)    f = greek_ext(cp[7:0]);
		else if (sym_hit)                                 f = sym;
		else if (drop)                                    f = none_str();
		else                                              f = utf8(cp);
		return f;
	endfunction

endpackage
`default_nettype wire

// ===== rtl/core/ugf_front.sv =====
`default_nettype none
module ugf_front import ugf_pkg::*; (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_stall,
	input  wire logic [20:0] code_point,
	input  wire logic        q_full,
	output q_port_t          push
);

	logic        valid_s1;
	logic [20:0] cp_s1;
	fold_t       fold_s1;
	logic        take;

	always_comb begin
		fold_s1    = fold_cp(cp_s1);
		push.valid = valid_s1 && (fold_s1.cnt != 3'd0) && !q_full;
		push.entry = fold_s1;
	end

	// dropped code points leave the stage without a queue slot
	assign in_stall = valid_s1 && (fold_s1.cnt != 3'd0) && q_full;
	assign take     = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (take) begin
			valid_s1 <= 1'b1;
		end else if (!in_stall) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			cp_s1 <= code_point;
		end
	end

endmodule
`default_nettype wire

// ===== rtl/core/ugf_queue.sv =====
`default_nettype none
module ugf_queue import ugf_pkg::*; (
	input  wire logic    clk,
	input  wire logic    arst_n,
	input  wire q_port_t push,
	input  wire logic    pop,
	output logic         full,
	output q_port_t      head
);

	fold_t            mem_q [QDepth];
	logic [QPtrW-1:0] wr_ptr_q;
	logic [QPtrW-1:0] rd_ptr_q;
	logic [QCntW-1:0] cnt_q;
	logic             do_push;
	logic             do_pop;

	assign full       = cnt_q == QCntW'(QDepth);
	assign head.valid = cnt_q != '0;
	assign head.entry = mem_q[rd_ptr_q];
	assign do_push    = push.valid && !full;
	assign do_pop     = pop && head.valid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			case ({do_push, do_pop})
				2'b10:   cnt_q <= cnt_q + 1'b1;
				2'b01:   cnt_q <= cnt_q - 1'b1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push.entry;
		end
	end

	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= QCntW'(QDepth))
		else $error("queue fill beyond depth");

	a_no_empty_pop: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> head.valid)
		else $error("pop from empty queue");

	a_push_counts: assert property (@(posedge clk) disable iff (!arst_n)
		(do_push && !do_pop) |=> cnt_q == $past(cnt_q) + 1'b1)
		else $error("push not counted");

endmodule
`default_nettype wire

// ===== rtl/core/ugf_back.sv =====
`default_nettype none
module ugf_back import ugf_pkg::*; (
	input  wire logic    clk,
	input  wire logic    arst_n,
	input  wire q_port_t head,
	output logic         pop,
	output logic         out_valid,
	input  wire logic    out_stall,
	output logic [7:0]   out_byte,
	output logic         last_byte
);

	logic [1:0] idx_q;
	logic       emit;
	logic       is_last;

	// output register frees when empty or taken this cycle
	assign emit    = head.valid && (!out_valid || !out_stall);
	assign is_last = {1'b0, idx_q} == (head.entry.cnt - 3'd1);
	assign pop     = emit && is_last;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
			idx_q     <= '0;
		end else begin
			if (emit) begin
				out_valid <= 1'b1;
				idx_q     <= is_last ? 2'd0 : idx_q + 2'd1;
			end else if (!out_stall) begin
				out_valid <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			out_byte  <= head.entry.bytes[idx_q];
			last_byte <= is_last;
		end
	end

	a_head_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		head.valid |-> (head.entry.cnt != 3'd0 && head.entry.cnt <= 3'd4))
		else $error("queue head holds an empty or oversized string");

	a_idx_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		head.valid |-> {1'b0, idx_q} < head.entry.cnt)
		else $error("byte index past string length");

	a_idx_idle: assert property (@(posedge clk) disable iff (!arst_n)
		!head.valid |-> idx_q == 2'd0)
		else $error("byte index left mid-string with empty queue");

endmodule
`default_nettype wire

// ===== rtl/core/unicode_glyph_fold_to_utf8_unit.sv =====
`default_nettype none
// channel | handshake            | fields              | beat
// --------+----------------------+---------------------+------------------------------------
// input   | in_valid, in_stall   | code_point          | one code point
// output  | out_valid, out_stall | out_byte, last_byte | one byte, last_byte on the final one
//
// a code point is taken every cycle while the two-entry queue has room
// output runs one byte a cycle while out_stall is low; an item folds to 1 to 4
// bytes, and dropped code points (0 bytes) never take a queue slot
// first byte passes the fold stage register, a queue entry and the output register
// reset clears all valid and pointer state; there is no clearing pass
// output stalls back up through the queue into in_stall
module unicode_glyph_fold_to_utf8_unit import ugf_pkg::*; (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_stall,
	input  wire logic [20:0] code_point,
	output logic             out_valid,
	input  wire logic        out_stall,
	output logic [7:0]       out_byte,
	output logic             last_byte
);

	q_port_t push;
	q_port_t head;
	logic    q_full;
	logic    pop;

	ugf_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.code_point (code_point),
		.q_full     (q_full),
		.push       (push)
	);

	ugf_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.pop    (pop),
		.full   (q_full),
		.head   (head)
	);

	ugf_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.head      (head),
		.pop       (pop),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_byte  (out_byte),
		.last_byte (last_byte)
	);

endmodule
`default_nettype wire
